### design/u16m8_pkg.sv
// Package for the UTF-16 to modified UTF-8 encoder.
// Holds the job descriptor passed from front to back and the byte-forming helpers.
// No dependencies.
`default_nettype none

package u16m8_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned MAX_BYTES  = 6;

  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] CONT  = 8'h80;

  localparam logic [15:0] HIGH_LO = 16'hD800;
  localparam logic [15:0] HIGH_HI = 16'hDBFF;
  localparam logic [15:0] LOW_LO  = 16'hDC00;
  localparam logic [15:0] LOW_HI  = 16'hDFFF;
  localparam logic [15:0] TWO_MAX = 16'h07FF;
  localparam logic [15:0] ONE_MAX = 16'h007F;

  // one queued job: the bytes caused by one accepted input word, emitted from index 0 up
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                len;
    logic                      last;
  } job_t;

  function automatic logic [2:0][7:0] three_bytes(input logic [15:0] u);
    logic [2:0][7:0] b;
    b[0] = LEAD3 | {4'h0, u[15:12]};
    b[1] = CONT  | {2'b00, u[11:6]};
    b[2] = CONT  | {2'b00, u[5:0]};
    return b;
  endfunction

  function automatic logic [3:0][7:0] four_bytes(input logic [9:0] hi, input logic [9:0] lo);
    logic [20:0]     cp;
    logic [3:0][7:0] b;
    cp   = {1'b0, hi, lo} + 21'h010000;
    b[0] = LEAD4 | {5'h00, cp[20:18]};
    b[1] = CONT  | {2'b00, cp[17:12]};
    b[2] = CONT  | {2'b00, cp[11:6]};
    b[3] = CONT  | {2'b00, cp[5:0]};
    return b;
  endfunction

endpackage

`default_nettype wire

### design/utf16_to_modified_utf8_encoder.sv
// UTF-16 to modified UTF-8 encoder, top level.
//
// Input channel (in_valid_i/in_ready_o): one UTF-16 code unit per word, with
// final_unit_i set on the last unit of a string. Output channel
// (out_valid_o/out_ready_i): one modified UTF-8 byte per word; run_end_o marks
// the last byte caused by an input word, string_end_o the last byte of a string.
// A non-final high surrogate is held back and produces no byte until the next
// unit arrives; a following low surrogate turns the pair into four bytes.
//
// With the pipeline empty, an accepted word is first written into the job queue
// and then loaded into the serialiser, which raises out_valid_o.
// Throughput: the serialiser sends one byte per cycle while out_ready_i is high,
// and a word yields 1 to 6 bytes (none for a held high surrogate). The front
// accepts one word per cycle while the job queue (FifoDepth entries) has room.
// Reset clears the held surrogate, the queue and the serialiser; nothing is
// pending afterwards. When the receiver stalls, the current byte holds, the
// queue fills and in_ready_o falls once it is full.
// Depends on u16m8_pkg, u16m8_front, u16m8_fifo, u16m8_back.
`default_nettype none

module utf16_to_modified_utf8_encoder #(
  parameter int unsigned FifoDepth = u16m8_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        final_unit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_end_o,
  output logic             string_end_o
);
  import u16m8_pkg::*;

  job_t push_job, pop_job;
  logic push, pop, full, empty;

  u16m8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_job_o      (push_job)
  );

  u16m8_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_job_o  (pop_job)
  );

  u16m8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (empty),
    .q_job_i      (pop_job),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

endmodule

`default_nettype wire

### design/u16m8_front.sv
// Front end: accepts code units, tracks a held high surrogate, builds byte jobs.
// Depends on u16m8_pkg.
`default_nettype none

module u16m8_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [15:0]      code_unit_i,
  input  wire logic             final_unit_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output u16m8_pkg::job_t       q_job_o
);
  import u16m8_pkg::*;

  logic            held_q, held_d;
  logic [9:0]      held_bits_q, held_bits_d;
  logic            accept;
  logic            is_high, is_low;
  logic [2:0][7:0] held3, new3;
  logic [3:0][7:0] pair4;
  logic [2:0][7:0] new_bytes;
  logic [1:0]      new_len;
  logic            hold_new;
  job_t            job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_high = (code_unit_i >= HIGH_LO) && (code_unit_i <= HIGH_HI);
  assign is_low  = (code_unit_i >= LOW_LO)  && (code_unit_i <= LOW_HI);

  assign held3 = three_bytes({6'b110110, held_bits_q});
  assign new3  = three_bytes(code_unit_i);
  assign pair4 = four_bytes(held_bits_q, code_unit_i[9:0]);

  // bytes of the new word on its own
  always_comb begin
    new_bytes = '0;
    new_len   = 2'd0;
    hold_new  = 1'b0;
    if (code_unit_i != 16'h0000 && code_unit_i <= ONE_MAX) begin
      new_bytes[0] = code_unit_i[7:0];
      new_len      = 2'd1;
    end else if (is_high && !final_unit_i) begin
      hold_new = 1'b1;
    end else if (code_unit_i > TWO_MAX) begin
      new_bytes = new3;
      new_len   = 2'd3;
    end else begin
      new_bytes[0] = LEAD2 | {3'b000, code_unit_i[10:6]};
      new_bytes[1] = CONT  | {2'b00, code_unit_i[5:0]};
      new_len      = 2'd2;
    end
  end

  always_comb begin
    job      = '0;
    job.last = final_unit_i;
    held_d      = held_q;
    held_bits_d = held_bits_q;
    if (held_q && is_low) begin
      job.bytes[3:0] = pair4;
      job.len        = 3'd4;
    end else if (held_q) begin
      job.bytes[2:0] = held3;
      job.bytes[5:3] = new_bytes;
      job.len        = 3'd3 + {1'b0, new_len};
    end else begin
      job.bytes[2:0] = new_bytes;
      job.len        = {1'b0, new_len};
    end
    if (accept) begin
      held_d      = hold_new && !(held_q && is_low);
      held_bits_d = held_d ? code_unit_i[9:0] : 10'h000;
    end
  end

  assign q_push_o = accept && (job.len != 3'd0);
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_bits_q <= 10'h000;
    end else begin
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
    end
  end

endmodule

`default_nettype wire

### design/u16m8_fifo.sv
// Short job queue between front and back.
// Depends on u16m8_pkg for the job type.
`default_nettype none

module u16m8_fifo #(
  parameter int unsigned Depth = u16m8_pkg::FIFO_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire u16m8_pkg::job_t  push_job_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output u16m8_pkg::job_t       pop_job_o
);
  import u16m8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### design/u16m8_back.sv
// Back end: takes jobs off the queue and emits their bytes one word per cycle while out_ready_i is high.
// Depends on u16m8_pkg.
`default_nettype none

module u16m8_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire u16m8_pkg::job_t  q_job_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_end_o,
  output logic                  string_end_o
);
  import u16m8_pkg::*;

  job_t       cur_q, cur_d;
  logic [2:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       last_byte;
  logic       sent;

  assign last_byte    = (idx_q == cur_q.len - 3'd1);
  assign sent         = busy_q && out_ready_i;
  assign q_pop_o      = !q_empty_i && (!busy_q || (sent && last_byte));

  assign out_valid_o  = busy_q;
  assign out_byte_o   = cur_q.bytes[idx_q];
  assign run_end_o    = last_byte;
  assign string_end_o = last_byte && cur_q.last;

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (q_pop_o) begin
      cur_d  = q_job_i;
      idx_d  = 3'd0;
      busy_d = 1'b1;
    end else if (sent) begin
      if (last_byte) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 3'd0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

### design/u16m8_checker.sv
// Port-level checks for the encoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module u16m8_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       run_end_i,
  input wire logic       string_end_i
);

  // a stalled byte holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(run_end_i) && $stable(string_end_i))
    else $error("stalled output word changed");

  a_str_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_end_i |-> run_end_i)
    else $error("string end without run end");

  // plain ASCII bytes are always the last byte of their unit
  a_ascii_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_i[7] |-> run_end_i)
    else $error("single-byte code not closing its run");

  // modified UTF-8 never carries a zero byte
  a_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_byte_i != 8'h00)
    else $error("zero byte emitted");

endmodule

bind utf16_to_modified_utf8_encoder u16m8_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_i   (out_byte_o),
  .run_end_i    (run_end_o),
  .string_end_i (string_end_o)
);

`default_nettype wire
